// ----- hdl/mtbr_pkg.sv -----
// Package for the mask-to-band-rectangles block: widths, register indexes,
// queue entry types and the coordinate scaling function. No dependencies.
`default_nettype none
package mtbr_pkg;
  localparam int MaxWidth  = 1024;
  localparam int MaxRuns   = 16;
  localparam int CoordW    = 11;
  localparam int RunIdxW   = $clog2(MaxRuns);
  localparam int RunCntW   = $clog2(MaxRuns + 1);
  localparam int OutW      = 14;
  localparam int ZoomW     = 12;
  localparam int CfgDataW  = 12;
  localparam int CfgIdxW   = 2;
  localparam int QDepth    = 4;
  localparam int QPtrW     = $clog2(QDepth);
  localparam logic [OutW-1:0] CoordMax = '1;

  typedef enum logic [CfgIdxW-1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_ZOOM   = 2'd2,
    REG_NONE   = 2'd3
  } cfg_idx_t;

  // One flush job handed from the front part to the back part.
  typedef struct packed {
    logic               row_flush;    // flush taken at a row change
    logic               frame_flush;  // flush taken at frame end
    logic [CoordW-1:0]  top_rc;       // band top row for the row-change flush
    logic [CoordW-1:0]  top_fe;       // band top row for the frame-end flush
    logic [CoordW-1:0]  end_row_rc;   // bottom row for the row-change flush
    logic [CoordW-1:0]  end_row_fe;   // bottom row for the frame-end flush
    logic [RunCntW-1:0] total_rc;     // runs in the band for row change
    logic [RunCntW-1:0] total_fe;     // runs in the band for frame end
    logic               ovf;
  } job_t;

  typedef enum logic [1:0] {
    BK_IDLE  = 2'd0,
    BK_RC    = 2'd1,
    BK_FE    = 2'd2
  } bk_state_t;

  // Scale a coordinate by Q4.8 zoom with round half up and saturation.
  function automatic logic [OutW-1:0] scale_coord(input logic [CoordW-1:0] c,
                                                   input logic [ZoomW-1:0] z);
    logic [CoordW+ZoomW:0] p;
    logic [CoordW+ZoomW-8:0] v;
    begin
      p = {1'b0, c} * {{(CoordW+1){1'b0}}, z} + (CoordW+ZoomW+1)'(128);
      v = p[CoordW+ZoomW:8];
      scale_coord = (v > (CoordW+ZoomW-7)'(CoordMax)) ? CoordMax : v[OutW-1:0];
    end
  endfunction
endpackage
`default_nettype wire

// ----- hdl/mtbr_if.sv -----
// Valid/ready channel interfaces for pixels and rectangles.
// Depends on mtbr_pkg for field widths.
`default_nettype none
interface mtbr_pix_if;
  logic valid;
  logic ready;
  logic pixel;
  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface

interface mtbr_rect_if;
  import mtbr_pkg::*;
  logic            valid;
  logic            ready;
  logic [OutW-1:0] left;
  logic [OutW-1:0] top;
  logic [OutW-1:0] right;
  logic [OutW-1:0] bottom;
  logic            last;
  logic            overflow;
  modport source (output valid, output left, output top, output right, output bottom,
                  output last, output overflow, input ready);
  modport sink   (input valid, input left, input top, input right, input bottom,
                  input last, input overflow, output ready);
endinterface
`default_nettype wire

// ----- hdl/mtbr_front.sv -----
// Front part: run detection per pixel, band comparison, and flush job issue.
// Depends on mtbr_pkg. Writes the band run store that the back part reads.
`default_nettype none
module mtbr_front
  import mtbr_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic [CoordW-1:0]  mask_width,
  input  wire logic [CoordW-1:0]  mask_height,
  input  wire logic               pix_valid,
  input  wire logic               pixel,
  output logic                    pix_ready,
  input  wire logic               back_busy,
  input  wire logic               rc_active,
  output logic                    copy_pend,
  output logic                    job_valid,
  output job_t                    job,
  input  wire logic [RunIdxW-1:0] rd_idx,
  output logic [CoordW-1:0]       rd_start,
  output logic [CoordW-1:0]       rd_end
);
  logic [CoordW-1:0]  col_r, row_r, band_r, open_r;
  logic               in_run_r, differ_r, ovf_r;
  logic [RunCntW-1:0] cur_tot_r, prev_tot_r;
  logic [CoordW-1:0]  cur_s_r [MaxRuns];
  logic [CoordW-1:0]  cur_e_r [MaxRuns];
  logic [CoordW-1:0]  prv_s_r [MaxRuns];
  logic [CoordW-1:0]  prv_e_r [MaxRuns];

  logic [CoordW-1:0]  w_eff, h_eff, run_s, run_e, row_inc;
  logic [CoordW:0]    col_inc;
  logic               acc, add, row_end, flush_rc, frame_end, do_add, add_ovf, add_diff;
  logic [RunCntW-1:0] tot_after;
  logic               diff_after;
  logic               pend_r;
  logic               copy_go;

  // The block holds a pixel off while the back part still drains the band store
  // or while the band copy is still owed.
  assign pix_ready = !back_busy && !pend_r;
  assign acc = pix_valid && pix_ready;
  assign copy_pend = pend_r;

  always_comb begin
    w_eff = (mask_width == '0) ? CoordW'(1) : mask_width;
    if (w_eff > CoordW'(MaxWidth)) w_eff = CoordW'(MaxWidth);
    h_eff = (mask_height == '0) ? CoordW'(1) : mask_height;
    col_inc = {1'b0, col_r} + 1'b1;
    row_end = col_inc >= {1'b0, w_eff};
    row_inc = row_r + 1'b1;
  end

  // One run at most closes per pixel: a falling edge or the row end.
  always_comb begin
    do_add = 1'b0;
    run_s  = open_r;
    run_e  = col_r;
    if (!pixel && in_run_r) begin
      do_add = 1'b1;
    end else if (row_end && (pixel || in_run_r)) begin
      do_add = 1'b1;
      run_s  = (pixel && !in_run_r) ? col_r : open_r;
      run_e  = col_inc[CoordW-1:0];
    end
    add = do_add && (run_e > run_s);
    add_ovf = add && (cur_tot_r >= RunCntW'(MaxRuns));
    add_diff = add_ovf || (add && ((cur_tot_r >= prev_tot_r)
               || prv_s_r[cur_tot_r[RunIdxW-1:0]] != run_s
               || prv_e_r[cur_tot_r[RunIdxW-1:0]] != run_e));
    tot_after  = (add && !add_ovf) ? cur_tot_r + 1'b1 : cur_tot_r;
    diff_after = differ_r || add_diff;
    flush_rc   = row_end && (diff_after || tot_after != prev_tot_r);
    frame_end  = row_end && ({1'b0, row_inc} >= {1'b0, h_eff} || row_inc == '0);
  end

  // Job issue toward the back part.
  always_comb begin
    job_valid      = acc && (flush_rc || frame_end);
    job.row_flush  = flush_rc && (prev_tot_r != '0);
    job.frame_flush = frame_end;
    job.top_rc     = band_r;
    job.top_fe     = flush_rc ? row_r : band_r;
    job.end_row_rc = row_r;
    job.end_row_fe = row_inc;
    job.total_rc   = prev_tot_r;
    job.total_fe   = flush_rc ? tot_after : prev_tot_r;
    job.ovf        = ovf_r || add_ovf;
  end

  assign rd_start = prv_s_r[rd_idx];
  assign rd_end   = prv_e_r[rd_idx];

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0; row_r <= '0; band_r <= '0; open_r <= '0;
      in_run_r <= 1'b0; differ_r <= 1'b0; ovf_r <= 1'b0;
      cur_tot_r <= '0; prev_tot_r <= '0;
    end else if (acc) begin
      if (pixel && !in_run_r) open_r <= col_r;
      if (!row_end) begin
        col_r <= col_inc[CoordW-1:0];
        in_run_r <= pixel;
        cur_tot_r <= tot_after;
        differ_r <= diff_after;
        ovf_r <= ovf_r || add_ovf;
      end else begin
        col_r <= '0;
        in_run_r <= 1'b0;
        cur_tot_r <= '0;
        differ_r <= 1'b0;
        if (frame_end) begin
          row_r <= '0; band_r <= '0; prev_tot_r <= '0; ovf_r <= 1'b0;
        end else begin
          row_r <= row_inc;
          ovf_r <= ovf_r || add_ovf;
          if (flush_rc) begin
            band_r <= row_r;
            prev_tot_r <= tot_after;
          end
        end
      end
    end
  end

  // Run stores. The band copy waits until the back part has read the old band
  // for the row-change list; the frame-end list then reads the new band.
  always_ff @(posedge clk) begin
    if (acc && add && !add_ovf) begin
      cur_s_r[cur_tot_r[RunIdxW-1:0]] <= run_s;
      cur_e_r[cur_tot_r[RunIdxW-1:0]] <= run_e;
    end
    if (copy_go) begin
      for (int i = 0; i < MaxRuns; i++) begin
        prv_s_r[i] <= cur_s_r[i];
        prv_e_r[i] <= cur_e_r[i];
      end
    end
  end

  // A band change owes a copy, taken once the row-change walk is over.
  always_ff @(posedge clk) begin
    if (!rst_n) pend_r <= 1'b0;
    else if (acc && flush_rc) pend_r <= 1'b1;
    else if (copy_go) pend_r <= 1'b0;
  end
  assign copy_go = pend_r && !rc_active;
endmodule
`default_nettype wire

// ----- hdl/mtbr_back.sv -----
// Back part: walks the band run store and produces scaled rectangles into a
// small output queue. Depends on mtbr_pkg and mtbr_rect_if.
`default_nettype none
module mtbr_back
  import mtbr_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic [ZoomW-1:0]   zoom_q,
  input  wire logic               job_valid,
  input  job_t                    job,
  input  wire logic               copy_pend,
  output logic                    busy,
  output logic                    rc_active,
  output logic [RunIdxW-1:0]      rd_idx,
  input  wire logic [CoordW-1:0]  rd_start,
  input  wire logic [CoordW-1:0]  rd_end,
  mtbr_rect_if.source             out
);
  typedef struct packed {
    logic [OutW-1:0] l, t, r, b;
    logic            last, ovf;
  } ent_t;

  bk_state_t st_r, st_nxt;
  job_t      job_r;
  logic [RunCntW-1:0] k_r, k_nxt;
  logic [RunCntW-1:0] tot;
  logic      emit, is_last, fe_empty;
  ent_t      q_r [QDepth];
  logic [QPtrW-1:0] wp_r, rp_r;
  logic [QPtrW:0]   cnt_r;
  logic      q_full, push, pop;

  assign q_full = cnt_r == (QPtrW+1)'(QDepth);
  assign tot = (st_r == BK_RC) ? job_r.total_rc : job_r.total_fe;
  assign rd_idx = k_r[RunIdxW-1:0];
  assign fe_empty = !job_r.frame_flush || job_r.total_fe == '0;

  // Next state.
  always_comb begin
    st_nxt = st_r;
    k_nxt  = k_r;
    unique case (st_r)
      BK_IDLE: begin
        if (job_valid) begin
          k_nxt = '0;
          if (job.row_flush) st_nxt = BK_RC;
          else if (job.frame_flush && job.total_fe != '0) st_nxt = BK_FE;
        end
      end
      BK_RC: begin
        if (emit) begin
          k_nxt = k_r + 1'b1;
          if (k_r + 1'b1 >= tot) begin
            k_nxt = '0;
            st_nxt = fe_empty ? BK_IDLE : BK_FE;
          end
        end
      end
      BK_FE: begin
        if (emit) begin
          k_nxt = k_r + 1'b1;
          if (k_r + 1'b1 >= tot) st_nxt = BK_IDLE;
        end
      end
      default: st_nxt = BK_IDLE;
    endcase
  end

  // Outputs of the walker. The frame-end list reads the store after the copy.
  always_comb begin
    emit = (st_r == BK_RC || (st_r == BK_FE && !copy_pend)) && !q_full;
    is_last = (k_r + 1'b1 >= tot) && (st_r == BK_FE || fe_empty);
    busy = st_r != BK_IDLE;
    rc_active = st_r == BK_RC;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= BK_IDLE; k_r <= '0;
    end else begin
      st_r <= st_nxt; k_r <= k_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == BK_IDLE && job_valid) job_r <= job;
  end

  // Output queue.
  assign push = emit;
  assign pop  = out.valid && out.ready;
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r].l    <= scale_coord(rd_start, zoom_q);
      q_r[wp_r].t    <= scale_coord((st_r == BK_RC) ? job_r.top_rc : job_r.top_fe,
                                    zoom_q);
      q_r[wp_r].r    <= scale_coord(rd_end, zoom_q);
      q_r[wp_r].b    <= scale_coord((st_r == BK_RC) ? job_r.end_row_rc : job_r.end_row_fe,
                                    zoom_q);
      q_r[wp_r].last <= is_last;
      q_r[wp_r].ovf  <= job_r.ovf;
    end
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop)  rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (QPtrW+1)'(push) - (QPtrW+1)'(pop);
    end
  end

  assign out.valid    = cnt_r != '0;
  assign out.left     = q_r[rp_r].l;
  assign out.top      = q_r[rp_r].t;
  assign out.right    = q_r[rp_r].r;
  assign out.bottom   = q_r[rp_r].b;
  assign out.last     = q_r[rp_r].last;
  assign out.overflow = q_r[rp_r].ovf;
endmodule
`default_nettype wire

// ----- hdl/mask_to_band_rectangles_top.sv -----
// Top level of the mask-to-band-rectangles block: configuration registers,
// front and back parts. Depends on mtbr_pkg, mtbr_if, mtbr_front, mtbr_back.
//
//   channel | dir | payload
//   in_     | in  | pixel
//   out_    | out | left, top, right, bottom, last, overflow
//   cfg_    | in  | wr_en, idx, data
//
// A pixel that ends no band does not hold the input. A pixel that flushes a band
// holds the input while the band walker emits a rectangle per run of the band,
// and while the band copy is owed when the row starts a new band; the walker
// reads one run store entry a cycle while the queue has room. Results wait in a
// four-entry queue; while it is full the walker and so the input stall. Reset
// is synchronous, active low, and clears all control state.
`default_nettype none
module mask_to_band_rectangles_top
  import mtbr_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  mtbr_pix_if.sink                 in_ch,
  mtbr_rect_if.source              out_ch,
  input  wire logic                cfg_wr_en,
  input  wire logic [CfgIdxW-1:0]  cfg_idx,
  input  wire logic [CfgDataW-1:0] cfg_data
);
  logic [CoordW-1:0] width_r, height_r;
  logic [ZoomW-1:0]  zoom_r;
  logic busy, job_valid, rc_active, copy_pend;
  job_t job;
  logic [RunIdxW-1:0] rd_idx;
  logic [CoordW-1:0]  rd_start, rd_end;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r <= CoordW'(256); height_r <= CoordW'(256); zoom_r <= ZoomW'(256);
    end else if (cfg_wr_en) begin
      unique case (cfg_idx_t'(cfg_idx))
        REG_WIDTH:  width_r  <= cfg_data[CoordW-1:0];
        REG_HEIGHT: height_r <= cfg_data[CoordW-1:0];
        REG_ZOOM:   zoom_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  mtbr_front u_front (
    .clk, .rst_n, .mask_width(width_r), .mask_height(height_r),
    .pix_valid(in_ch.valid), .pixel(in_ch.pixel), .pix_ready(in_ch.ready),
    .back_busy(busy), .rc_active, .copy_pend, .job_valid, .job,
    .rd_idx, .rd_start, .rd_end
  );

  mtbr_back u_back (
    .clk, .rst_n, .zoom_q(zoom_r), .job_valid, .job, .copy_pend, .busy, .rc_active,
    .rd_idx, .rd_start, .rd_end, .out(out_ch)
  );
endmodule
`default_nettype wire

// ----- hdl/mtbr_checker.sv -----
// Port-level checker for the mask-to-band-rectangles top level, with bind.
// Depends on mtbr_pkg and the top-level port list.
`default_nettype none
module mtbr_port_props
  import mtbr_pkg::*;
(
  input wire logic clk,
  input wire logic rst_n,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic out_last,
  input wire logic out_overflow,
  input wire logic [OutW-1:0] out_left,
  input wire logic [OutW-1:0] out_right
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
  a_edges: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_right >= out_left) else $error("right below left");
  a_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last && out_overflow |=> !out_valid || out_overflow)
    else $error("overflow fell inside a burst");
endmodule

bind mask_to_band_rectangles_top mtbr_port_props u_chk (
  .clk, .rst_n, .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_last(out_ch.last), .out_overflow(out_ch.overflow),
  .out_left(out_ch.left), .out_right(out_ch.right)
);
`default_nettype wire

// ----- verif/mtbr_checker.sv -----
// Checker for the mask-to-band-rectangles block: watches the pixel, rectangle
// and register ports, predicts every rectangle and compares it field by field.
// Depends on mtbr_pkg and the channel interfaces in mtbr_if.
module mtbr_checker
  import mtbr_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  mtbr_pix_if                 pix,
  mtbr_rect_if                rect,
  input  logic                cfg_wr_en,
  input  logic [CfgIdxW-1:0]  cfg_idx,
  input  logic [CfgDataW-1:0] cfg_data,
  output int                  fail_count,
  output int                  rects_pending
);
  typedef struct {
    logic [OutW-1:0] left;
    logic [OutW-1:0] top;
    logic [OutW-1:0] right;
    logic [OutW-1:0] bottom;
    logic            last;
    logic            overflow;
  } rect_t;

  rect_t rect_fifo[$];

  // Shadow of the registers and of the band tracking state.
  logic [CoordW-1:0] width_reg, height_reg;
  logic [ZoomW-1:0]  zoom_reg;
  int  col_cnt, row_cnt, band_top, open_start, cur_total, prev_total;
  bit  run_open, row_changed, ovf_seen;
  int  cur_starts[MaxRuns], cur_ends[MaxRuns];
  int  prev_starts[MaxRuns], prev_ends[MaxRuns];

  function automatic logic [OutW-1:0] zoomed(int c);
    int v;
    v = (c * int'(zoom_reg) + 128) >>> 8;
    return (v > 16383) ? OutW'(16383) : OutW'(v);
  endfunction

  // Close a run into the current row's list; extra runs mark overflow.
  task automatic close_run(int s, int e);
    if (e <= s) return;
    if (cur_total >= MaxRuns) begin
      ovf_seen = 1;
      row_changed = 1;
      return;
    end
    if (cur_total >= prev_total || prev_starts[cur_total] != s ||
        prev_ends[cur_total] != e) row_changed = 1;
    cur_starts[cur_total] = s;
    cur_ends[cur_total] = e;
    cur_total++;
  endtask

  // One rectangle per run of the band above.
  task automatic emit_band(int end_row);
    rect_t r;
    for (int k = 0; k < prev_total; k++) begin
      r.left = zoomed(prev_starts[k]);
      r.top = zoomed(band_top);
      r.right = zoomed(prev_ends[k]);
      r.bottom = zoomed(end_row);
      r.last = 0;
      r.overflow = ovf_seen;
      rect_fifo.insert(rect_fifo.size(), r);
    end
  endtask

  task automatic take_pixel(bit p);
    int w, h, col, before_cnt;
    w = (width_reg == 0) ? 1 : int'(width_reg);
    h = (height_reg == 0) ? 1 : int'(height_reg);
    if (w > MaxWidth) w = MaxWidth;
    col = col_cnt;
    if (p && !run_open) begin
      open_start = col;
      run_open = 1;
    end else if (!p && run_open) begin
      close_run(open_start, col);
      run_open = 0;
    end
    if (col + 1 < w) begin
      col_cnt = col + 1;
      return;
    end
    // Row end: compare with the band, then check for frame end.
    before_cnt = rect_fifo.size();
    if (run_open) close_run(open_start, col + 1);
    run_open = 0;
    if (row_changed || cur_total != prev_total) begin
      emit_band(row_cnt);
      prev_starts = cur_starts;
      prev_ends = cur_ends;
      prev_total = cur_total;
      band_top = row_cnt;
    end
    cur_total = 0;
    row_changed = 0;
    col_cnt = 0;
    row_cnt++;
    if (row_cnt >= h) begin
      emit_band(row_cnt);
      row_cnt = 0;
      band_top = 0;
      prev_total = 0;
      ovf_seen = 0;
    end
    if (rect_fifo.size() > before_cnt) rect_fifo[rect_fifo.size()-1].last = 1;
  endtask

  always @(posedge clk) begin
    rect_t exp_r;
    if (!rst_n) begin
      width_reg = 256;
      height_reg = 256;
      zoom_reg = 256;
      col_cnt = 0; row_cnt = 0; band_top = 0; open_start = 0;
      cur_total = 0; prev_total = 0;
      run_open = 0; row_changed = 0; ovf_seen = 0;
      rect_fifo.delete();
      fail_count = 0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_idx)
          REG_WIDTH:  width_reg = cfg_data[CoordW-1:0];
          REG_HEIGHT: height_reg = cfg_data[CoordW-1:0];
          REG_ZOOM:   zoom_reg = cfg_data[ZoomW-1:0];
          default: ;
        endcase
      end
      if (pix.valid && pix.ready) take_pixel(pix.pixel);
      // Compare each rectangle beat with the oldest prediction.
      if (rect.valid && rect.ready) begin
        if (rect_fifo.size() == 0) begin
          $error("rectangle beat with nothing predicted");
          fail_count++;
        end else begin
          exp_r = rect_fifo.pop_front();
          if (rect.left !== exp_r.left) begin
            $error("left: expected %0d, got %0d", exp_r.left, rect.left);
            fail_count++;
          end
          if (rect.top !== exp_r.top) begin
            $error("top: expected %0d, got %0d", exp_r.top, rect.top);
            fail_count++;
          end
          if (rect.right !== exp_r.right) begin
            $error("right: expected %0d, got %0d", exp_r.right, rect.right);
            fail_count++;
          end
          if (rect.bottom !== exp_r.bottom) begin
            $error("bottom: expected %0d, got %0d", exp_r.bottom, rect.bottom);
            fail_count++;
          end
          if (rect.last !== exp_r.last) begin
            $error("last: expected %0d, got %0d", exp_r.last, rect.last);
            fail_count++;
          end
          if (rect.overflow !== exp_r.overflow) begin
            $error("overflow: expected %0d, got %0d", exp_r.overflow, rect.overflow);
            fail_count++;
          end
        end
      end
    end
    rects_pending = rect_fifo.size();
  end
endmodule

// ----- verif/tb_top.sv -----
// Top of the mask-to-band-rectangles testbench: clock, reset, pixel stimulus,
// register writes, output stalls and the verdict. Depends on mtbr_pkg,
// mtbr_if, mtbr_checker and mask_to_band_rectangles_top.
module tb_top;
  import mtbr_pkg::*;

  localparam int StallLimit = 20000;
  localparam int HoldCycles = 400;

  logic                clk;
  logic                rst_n;
  logic                cfg_wr_en;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_data;
  int                  fail_count, rects_pending;
  int                  tx_idle_pct, rx_stall_pct;
  int                  hold_reqs, holds_done, hold_left, quiet_cycles;
  bit                  row_bits[MaxWidth];

  mtbr_pix_if  pix_ch();
  mtbr_rect_if rect_ch();

  mask_to_band_rectangles_top u_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(pix_ch), .out_ch(rect_ch),
    .cfg_wr_en(cfg_wr_en), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
  );

  mtbr_checker u_checker (
    .clk(clk), .rst_n(rst_n), .pix(pix_ch), .rect(rect_ch),
    .cfg_wr_en(cfg_wr_en), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
    .fail_count(fail_count), .rects_pending(rects_pending)
  );

  initial begin
    clk = 0;
    rst_n = 0;
    cfg_wr_en = 0;
    cfg_idx = REG_NONE;
    cfg_data = '0;
    pix_ch.valid = 0;
    pix_ch.pixel = 0;
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    hold_reqs = 0;
  end

  always #6 clk = ~clk;

  // Receiver: random stalls, plus a long hold-off on request.
  always @(posedge clk) begin
    if (!rst_n) begin
      holds_done <= 0;
      hold_left <= 0;
      rect_ch.ready <= 0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      rect_ch.ready <= 0;
    end else if (holds_done != hold_reqs) begin
      holds_done <= hold_reqs;
      hold_left <= HoldCycles;
      rect_ch.ready <= 0;
    end else begin
      rect_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // Watchdog on cycles without any beat on either channel.
  always @(posedge clk) begin
    if (!rst_n || (pix_ch.valid && pix_ch.ready) || (rect_ch.valid && rect_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Writes all three registers on consecutive cycles.
  task automatic write_regs(logic [CfgDataW-1:0] w, logic [CfgDataW-1:0] h,
                            logic [CfgDataW-1:0] z);
    cfg_wr_en <= 1;
    cfg_idx <= REG_WIDTH;
    cfg_data <= w;
    @(posedge clk);
    cfg_idx <= REG_HEIGHT;
    cfg_data <= h;
    @(posedge clk);
    cfg_idx <= REG_ZOOM;
    cfg_data <= z;
    @(posedge clk);
    cfg_wr_en <= 0;
    cfg_idx <= REG_NONE;
    @(posedge clk);
  endtask

  // Offers one pixel beat, with random idle cycles ahead of it.
  task automatic send_pixel(bit p);
    while ($urandom_range(99) < tx_idle_pct) begin
      pix_ch.valid <= 0;
      @(posedge clk);
    end
    pix_ch.valid <= 1;
    pix_ch.pixel <= p;
    @(negedge clk);
    while (!pix_ch.ready) @(negedge clk);
    @(posedge clk);
  endtask

  // Waits until every predicted rectangle is out and the block has settled.
  task automatic drain();
    pix_ch.valid <= 0;
    @(posedge clk);
    while (rects_pending > 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // Sends rows of width w; rows often repeat the one above to grow bands.
  task automatic send_rows(int rows, int w, int density);
    for (int r = 0; r < rows; r++) begin
      if (r == 0 || $urandom_range(99) < 45) begin
        for (int c = 0; c < w; c++) row_bits[c] = ($urandom_range(99) < density);
      end
      for (int c = 0; c < w; c++) send_pixel(row_bits[c]);
    end
  endtask

  initial begin
    int w, h, z, rows;
    repeat (5) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: a simple band change and frame end at unity zoom.
    write_regs(12'd4, 12'd3, 12'd256);
    for (int i = 0; i < 12; i++) send_pixel(i < 8);
    drain();
    // Zero width and height act as single-pixel frames; zero zoom.
    write_regs(12'd0, 12'd0, 12'd0);
    send_pixel(1'b1);
    send_pixel(1'b0);
    send_pixel(1'b1);
    drain();
    // Alternating pixels overflow the run store, largest zoom.
    write_regs(12'd34, 12'd1, 12'd4095);
    for (int i = 0; i < 34; i++) send_pixel(i % 2 == 0);
    drain();
    // Shrinking the width mid-row ends the row at the current pixel.
    write_regs(12'd20, 12'd4, 12'd1);
    for (int i = 0; i < 12; i++) send_pixel(i > 3);
    drain();
    write_regs(12'd5, 12'd4, 12'd300);
    for (int i = 0; i < 10; i++) send_pixel(1'b1);
    drain();

    // Random frames under each idling mode.
    for (int mode = 0; mode < 4; mode++) begin
      tx_idle_pct = (mode == 1 || mode == 3) ? ((mode == 1) ? 67 : 17) : 0;
      rx_stall_pct = (mode == 2 || mode == 3) ? ((mode == 2) ? 67 : 17) : 0;
      if (mode == 0) hold_reqs++;
      for (int f = 0; f < 5; f++) begin
        w = ($urandom_range(9) == 0) ? $urandom_range(33, 40) : $urandom_range(1, 6);
        h = $urandom_range(1, 4);
        case ($urandom_range(5))
          0: z = 0;
          1: z = 4095;
          2: z = 256;
          default: z = $urandom_range(1, 4095);
        endcase
        write_regs(CfgDataW'(w), CfgDataW'(h), CfgDataW'(z));
        rows = h;
        // Some frames stop short so the next geometry starts mid-frame.
        if ($urandom_range(3) == 0) rows = $urandom_range(0, h);
        send_rows(rows, w, (w > 30) ? 50 : $urandom_range(10, 90));
        if ($urandom_range(3) == 0) begin
          for (int i = 0; i < 3; i++) send_pixel(1'($urandom_range(1)));
        end
        drain();
      end
    end

    tx_idle_pct = 0;
    rx_stall_pct = 0;
    drain();
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
